### hw/rtl/mhic_pkg.sv
// Package for the Matern half-integer covariance pipeline: constants, codes and root table.
package mhic_pkg;

  localparam int DIM = 2;
  localparam int EXP_TABLE_BITS_DEF = 8;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHNESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_RATE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE   = 8'd2;

  typedef enum logic [1:0] {
    MODE_NU_HALF       = 2'd0,
    MODE_NU_THREE_HALF = 2'd1,
    MODE_NU_FIVE_HALF  = 2'd2,
    MODE_UNUSED        = 2'd3
  } mode_t;

  localparam logic [31:0] RESET_RATE  = 32'd16777216;
  localparam logic [31:0] RESET_SCALE = 32'd65536;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  // Reciprocal of three, rounded up, scaled by 2^33.
  localparam logic [31:0] RECIP3_Q33 = 32'hAAAAAAAB;
  localparam logic [22:0] H_CAP = 23'd4194304;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Square root stages resolve this many result bits each.
  localparam int SQ_BITS_PER_STAGE = 4;
  localparam int SQ_STAGES = 32 / SQ_BITS_PER_STAGE;

  function automatic logic [31:0] isqrt64(input logic [63:0] x);
    logic [65:0] rem;
    logic [65:0] trial;
    logic [31:0] root;
    rem  = {2'b00, x};
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = ({34'd0, root} << (i + 1)) + (66'd1 << (2 * i));
      if (trial <= rem) begin
        rem = rem - trial;
        root[i] = 1'b1;
      end
    end
    return root;
  endfunction

  // 2^(-2^-j) in Q0.32, built by repeated square roots of one half.
  function automatic logic [31:0] root_q32(input int j);
    logic [31:0] g;
    g = 32'h8000_0000;
    for (int n = 0; n < j; n++) begin
      g = isqrt64({g, 32'd0});
    end
    return g;
  endfunction

endpackage

### hw/rtl/matern_half_integer_covariance.sv
// Top level of the Matern half-integer covariance pipeline.
//
// Streams point pairs and returns one covariance per pair. A transaction can enter
// every cycle unless in_stall is high. The pipeline depth is set by the eight-stage
// square root, four bits per stage, and by the exponent product chain, which spends
// one multiplier stage per index bit. The whole pipeline advances together and holds
// while a finished result is stalled at the output, so nothing is lost or repeated.
// Configuration is written through the cfg_ port, always ready, and must only change
// while no transaction is in flight.
module matern_half_integer_covariance #(
  parameter int EXP_TABLE_BITS = mhic_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             in_point_a_x,
  input  logic signed [31:0]             in_point_a_y,
  input  logic signed [31:0]             in_point_b_x,
  input  logic signed [31:0]             in_point_b_y,
  input  logic [15:0]                    in_row_tag,
  input  logic [15:0]                    in_col_tag,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_row_out,
  output logic [15:0]                    out_col_out,
  output logic [31:0]                    out_covariance,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mhic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int EB  = EXP_TABLE_BITS;
  localparam int SQS = mhic_pkg::SQ_STAGES;
  localparam int SQB = mhic_pkg::SQ_BITS_PER_STAGE;
  localparam int DM  = mhic_pkg::DIM;
  // Total register stages from input to output.
  localparam int LAT = 11 + SQS + EB;

  // Configuration registers.
  mhic_pkg::mode_t mode_r;
  logic [31:0]     rate_r;
  logic [31:0]     scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= mhic_pkg::MODE_NU_HALF;
      rate_r  <= mhic_pkg::RESET_RATE;
      scale_r <= mhic_pkg::RESET_SCALE;
    end else if (cfg_valid) begin
      case (cfg_index)
        mhic_pkg::REG_SMOOTHNESS: mode_r  <= mhic_pkg::mode_t'(cfg_data[1:0]);
        mhic_pkg::REG_RANGE_RATE: rate_r  <= cfg_data;
        mhic_pkg::REG_VARIANCE:   scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one; it only holds when the output is stalled.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Valid bits and tags travel in delay lines alongside the data stages.
  logic        vld_r [LAT];
  logic [15:0] row_r [LAT];
  logic [15:0] col_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r[0] <= in_row_tag;
      col_r[0] <= in_col_tag;
      for (int i = 1; i < LAT; i++) begin
        row_r[i] <= row_r[i-1];
        col_r[i] <= col_r[i-1];
      end
    end
  end

  // Stage 1: absolute coordinate differences, exact in 32 bits.
  logic signed [31:0] pa [DM];
  logic signed [31:0] pb [DM];
  logic [31:0]        ad_nxt [DM];
  logic [31:0]        ad_r [DM];
  assign pa[0] = in_point_a_x;
  assign pa[1] = in_point_a_y;
  assign pb[0] = in_point_b_x;
  assign pb[1] = in_point_b_y;

  always_comb begin
    logic signed [32:0] d;
    logic [32:0]        m;
    for (int i = 0; i < DM; i++) begin
      d = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
      m = d[32] ? 33'(-d) : 33'(d);
      ad_nxt[i] = m[31:0];
    end
  end

  // Stage 2: squares. Stage 3: sum of quarter squares in units of 2^-30.
  logic [63:0] sq_r [DM];
  logic [63:0] s_r;
  logic [63:0] s_nxt;

  always_comb begin
    s_nxt = '0;
    for (int i = 0; i < DM; i++) s_nxt = s_nxt + {2'b00, sq_r[i][63:2]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DM; i++) begin
        ad_r[i] <= ad_nxt[i];
        sq_r[i] <= ad_r[i] * ad_r[i];
      end
      s_r <= s_nxt;
    end
  end

  // Square root: each stage settles SQB result bits from the running remainder.
  logic [31:0] rt_r [SQS];
  logic [65:0] rm_r [SQS];

  for (genvar g = 0; g < SQS; g++) begin : g_sqrt
    logic [31:0] rt_in;
    logic [65:0] rm_in;
    logic [31:0] rt_nxt;
    logic [65:0] rm_nxt;
    if (g == 0) begin : g_first
      assign rt_in = '0;
      assign rm_in = {2'b00, s_r};
    end else begin : g_rest
      assign rt_in = rt_r[g-1];
      assign rm_in = rm_r[g-1];
    end
    always_comb begin
      logic [65:0] trial;
      int          bi;
      rt_nxt = rt_in;
      rm_nxt = rm_in;
      for (int s = 0; s < SQB; s++) begin
        bi    = 31 - g * SQB - s;
        trial = ({34'd0, rt_nxt} << (bi + 1)) + (66'd1 << (2 * bi));
        if (trial <= rm_nxt) begin
          rm_nxt     = rm_nxt - trial;
          rt_nxt[bi] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[g] <= rt_nxt;
        rm_r[g] <= rm_nxt;
      end
    end
  end

  // Scaled distance, then h in Q16.16 capped at 64.0.
  logic [63:0] prod_r;
  logic [22:0] h_r;
  logic [40:0] h_full;
  assign h_full = prod_r[63:23];

  // h squared over 2^16 and h times log2(e), side by side.
  logic [45:0] hsq;
  logic [53:0] hlog;
  logic [29:0] hh_r;
  logic [23:0] t_r;
  logic [22:0] h1_r;
  logic        hz1_r;
  assign hsq  = h_r * h_r;
  assign hlog = h_r * mhic_pkg::LOG2E_Q30;

  // Division by three through the reciprocal; split t into integer and fraction.
  logic [61:0] q3full;
  logic [26:0] q3_r;
  logic [7:0]  k2_r;
  logic [EB-1:0] idx2_r;
  logic [22:0] h2_r;
  logic        hz2_r;
  assign q3full = hh_r * mhic_pkg::RECIP3_Q33;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= rt_r[SQS-1] * rate_r;
      h_r    <= (h_full > 41'(mhic_pkg::H_CAP)) ? mhic_pkg::H_CAP : h_full[22:0];
      hh_r   <= hsq[45:16];
      t_r    <= hlog[53:30];
      h1_r   <= h_r;
      hz1_r  <= (h_r == '0);
      q3_r   <= q3full[59:33];
      k2_r   <= t_r[23:16];
      idx2_r <= t_r[15 -: EB];
      h2_r   <= h1_r;
      hz2_r  <= hz1_r;
    end
  end

  // Polynomial by mode, and the start of the exponent product chain.
  logic [26:0]   p_nxt;
  logic [26:0]   pc_r  [EB+1];
  logic [32:0]   mc_r  [EB+1];
  logic [7:0]    kc_r  [EB+1];
  logic [EB-1:0] ic_r  [EB+1];
  logic          hzc_r [EB+1];

  always_comb begin
    case (mode_r)
      mhic_pkg::MODE_NU_THREE_HALF: p_nxt = 27'(mhic_pkg::ONE_Q16) + 27'(h2_r);
      mhic_pkg::MODE_NU_FIVE_HALF:  p_nxt = 27'(mhic_pkg::ONE_Q16) + 27'(h2_r) + q3_r;
      default:                      p_nxt = 27'(mhic_pkg::ONE_Q16);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r[0]  <= p_nxt;
      mc_r[0]  <= 33'h1_0000_0000;
      kc_r[0]  <= k2_r;
      ic_r[0]  <= idx2_r;
      hzc_r[0] <= hz2_r;
    end
  end

  // One root factor per index bit, lowest bit first.
  for (genvar b = 0; b < EB; b++) begin : g_chain
    localparam logic [31:0] G = mhic_pkg::root_q32(EB - b);
    logic [64:0] mg;
    assign mg = mc_r[b] * G;
    always_ff @(posedge clk) begin
      if (en) begin
        mc_r[b+1]  <= ic_r[b][b] ? mg[64:32] : mc_r[b];
        pc_r[b+1]  <= pc_r[b];
        kc_r[b+1]  <= kc_r[b];
        ic_r[b+1]  <= ic_r[b];
        hzc_r[b+1] <= hzc_r[b];
      end
    end
  end

  // Product, power-of-two shift with clamp, then the scale.
  logic [59:0] pm_r;
  logic [7:0]  kp_r;
  logic        hzp_r;
  logic [59:0] fsh;
  logic [16:0] f_nxt;
  logic [16:0] f_r;
  logic        hzf_r;
  logic [31:0] cov_nxt;
  logic [48:0] vf;
  logic [31:0] cov_r;

  assign fsh = pm_r >> (6'd32 + {1'b0, kp_r[4:0]});

  always_comb begin
    if (kp_r >= 8'd32) f_nxt = '0;
    else if (fsh > 60'(mhic_pkg::ONE_Q16)) f_nxt = mhic_pkg::ONE_Q16;
    else f_nxt = fsh[16:0];
  end

  assign vf = scale_r * f_r;

  always_comb begin
    if (hzf_r) cov_nxt = scale_r;
    else if (mode_r == mhic_pkg::MODE_UNUSED) cov_nxt = '0;
    else cov_nxt = vf[47:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r  <= pc_r[EB] * mc_r[EB];
      kp_r  <= kc_r[EB];
      hzp_r <= hzc_r[EB];
      f_r   <= f_nxt;
      hzf_r <= hzp_r;
      cov_r <= cov_nxt;
    end
  end

  assign out_valid      = vld_r[LAT-1];
  assign out_row_out    = row_r[LAT-1];
  assign out_col_out    = col_r[LAT-1];
  assign out_covariance = cov_r;

  // The exponent factor never exceeds one, so the result does not exceed the scale.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-2] |-> (f_r <= mhic_pkg::ONE_Q16))
    else $error("exponent factor above one");

  // A stalled result holds its place and value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_covariance)
                                  && $stable(out_row_out)))
    else $error("stalled result changed");

  // No transaction enters while the pipeline is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r[0]))
    else $error("pipeline moved under stall");

endmodule
